// ===== rtl/frs_pkg.sv =====
package frs_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL   = 10'b00_0000_0010,
    S_ADD   = 10'b00_0000_0100,
    S_GTWO  = 10'b00_0000_1000,
    S_GAODD = 10'b00_0001_0000,
    S_GLOOP = 10'b00_0010_0000,
    S_GSHL  = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_CHK   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } frs_state_e;

endpackage

// ===== rtl/fraction_running_sum.sv =====
// Sequence: a shift-add multiply, one add step, a binary gcd, a bit-serial divide
// and a range check; a zero denominator skips straight to the result, and a zero
// sum skips the gcd, the divide and the range check.
// Throughput: one transaction at a time; the multiply, gcd and divide loops set it.
// Reset: asynchronous, active low; the running sum returns to 0/1.
module fraction_running_sum #(
  parameter int SUM_WIDTH = 64,
  parameter int IN_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IN_WIDTH-1:0]  frac_numer_i,
  input  logic [IN_WIDTH-1:0]  frac_denom_i,
  input  logic                 last_of_list_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SUM_WIDTH-1:0] sum_numer_o,
  output logic [SUM_WIDTH-2:0] sum_denom_o,
  output logic [1:0]           status_o,
  output logic                 list_done_o
);
  import frs_pkg::*;

  localparam int S  = SUM_WIDTH;
  localparam int I  = IN_WIDTH;
  localparam int W  = S + I;
  localparam int CW = $clog2(W + 1);

  frs_state_e state_q, state_d;

  logic [S-1:0]  acc_numer_q, acc_numer_d;
  logic [S-2:0]  acc_denom_q, acc_denom_d;
  logic          last_q, last_d, s1_q, s1_d, s2_q, s2_d, st_q, st_d;
  logic [W-1:0]  mc1_q, mc1_d, mc2_q, mc2_d;
  logic [I-1:0]  mlt_d_q, mlt_d_d, mlt_n_q, mlt_n_d;
  logic [W-1:0]  p1_q, p1_d, p2_q, p2_d, den_q, den_d, t_q, t_d;
  logic [W-1:0]  a_q, a_d, b_q, b_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [S-1:0]  res_numer_q, res_numer_d;
  logic [S-2:0]  res_denom_q, res_denom_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          res_last_q, res_last_d;

  logic          n_neg, d_neg;
  logic [I-1:0]  mn, md;
  logic [S-1:0]  ma;
  logic [W:0]    t_sum, t_ab, t_ba;
  logic [W:0]    g_ba, g_ab;
  logic          div_start, div_done, div_done_d;
  logic [W-1:0]  qn, qd;
  logic          ovf;
  logic [S-1:0]  new_numer;

  // Input magnitudes and signs
  assign n_neg = frac_numer_i[I-1];
  assign d_neg = frac_denom_i[I-1];
  assign mn    = n_neg ? -frac_numer_i : frac_numer_i;
  assign md    = d_neg ? -frac_denom_i : frac_denom_i;
  assign ma    = acc_numer_q[S-1] ? -acc_numer_q : acc_numer_q;

  // Signed combination of the two cross products
  assign t_sum = {1'b0, p1_q} + {1'b0, p2_q};
  assign t_ab  = {1'b0, p1_q} - {1'b0, p2_q};
  assign t_ba  = {1'b0, p2_q} - {1'b0, p1_q};

  // Gcd subtract step, both directions
  assign g_ba = {1'b0, b_q} - {1'b0, a_q};
  assign g_ab = {1'b0, a_q} - {1'b0, b_q};

  // Reduced value range check
  assign ovf = (|qd[W-1:S-1]) ||
               (st_q ? ((|qn[W-1:S]) || (qn[S-1] && (|qn[S-2:0])))
                     : (|qn[W-1:S-1]));
  assign new_numer = st_q ? -qn[S-1:0] : qn[S-1:0];

  assign div_start = (state_q == S_GSHL) && (k_q == '0);

  always_comb begin
    state_d      = state_q;
    acc_numer_d  = acc_numer_q;
    acc_denom_d  = acc_denom_q;
    last_d       = last_q;
    s1_d         = s1_q;
    s2_d         = s2_q;
    st_d         = st_q;
    mc1_d        = mc1_q;
    mc2_d        = mc2_q;
    mlt_d_d      = mlt_d_q;
    mlt_n_d      = mlt_n_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    den_d        = den_q;
    t_d          = t_q;
    a_d          = a_q;
    b_d          = b_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    res_numer_d  = res_numer_q;
    res_denom_d  = res_denom_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_of_list_i;
          if (frac_denom_i == '0) begin
            // Reject the transaction, report the kept sum
            res_numer_d  = acc_numer_q;
            res_denom_d  = acc_denom_q;
            res_status_d = ST_ZERO_DEN;
            res_last_d   = last_of_list_i;
            if (last_of_list_i) begin
              acc_numer_d = '0;
              acc_denom_d = (S - 1)'(1);
            end
            state_d = S_OUT;
          end else begin
            mc1_d   = W'(ma);
            mc2_d   = W'(acc_denom_q);
            mlt_d_d = md;
            mlt_n_d = mn;
            p1_d    = '0;
            p2_d    = '0;
            den_d   = '0;
            cnt_d   = '0;
            s1_d    = acc_numer_q[S-1];
            s2_d    = n_neg ^ d_neg;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        // Shift-add, one multiplier bit per cycle
        if (mlt_d_q[0]) begin
          p1_d  = p1_q + mc1_q;
          den_d = den_q + mc2_q;
        end
        if (mlt_n_q[0]) begin
          p2_d = p2_q + mc2_q;
        end
        mc1_d   = {mc1_q[W-2:0], 1'b0};
        mc2_d   = {mc2_q[W-2:0], 1'b0};
        mlt_d_d = mlt_d_q >> 1;
        mlt_n_d = mlt_n_q >> 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CW'(I - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (s1_q == s2_q) begin
          t_d  = t_sum[W-1:0];
          st_d = s1_q;
        end else if (!t_ab[W]) begin
          t_d  = t_ab[W-1:0];
          st_d = s1_q;
        end else begin
          t_d  = t_ba[W-1:0];
          st_d = s2_q;
        end
        a_d = t_d;
        b_d = den_q;
        k_d = '0;
        if (t_d == '0) begin
          // Zero sum reduces to 0/1
          res_numer_d  = '0;
          res_denom_d  = (S - 1)'(1);
          res_status_d = ST_OK;
          res_last_d   = last_q;
          acc_numer_d  = '0;
          acc_denom_d  = (S - 1)'(1);
          state_d      = S_OUT;
        end else begin
          state_d = S_GTWO;
        end
      end
      S_GTWO: begin
        // Strip common factors of two
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = S_GAODD;
        end
      end
      S_GAODD: begin
        if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else begin
          state_d = S_GLOOP;
        end
      end
      S_GLOOP: begin
        if (b_q == '0) begin
          state_d = S_GSHL;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!g_ba[W]) begin
          b_d = g_ba[W-1:0];
        end else begin
          a_d = b_q;
          b_d = g_ab[W-1:0];
        end
      end
      S_GSHL: begin
        // Restore the common power of two
        if (k_q != '0) begin
          a_d = {a_q[W-2:0], 1'b0};
          k_d = k_q - 1'b1;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        res_last_d = last_q;
        if (ovf) begin
          res_numer_d  = acc_numer_q;
          res_denom_d  = acc_denom_q;
          res_status_d = ST_OVERFLOW;
        end else begin
          res_numer_d  = new_numer;
          res_denom_d  = qd[S-2:0];
          res_status_d = ST_OK;
          acc_numer_d  = new_numer;
          acc_denom_d  = qd[S-2:0];
        end
        if (last_q) begin
          acc_numer_d = '0;
          acc_denom_d = (S - 1)'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Numerator and denominator quotients by the gcd
  frs_div #(.W(W)) u_div_numer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (t_q),
    .divisor_i  (a_q),
    .quot_o     (qn),
    .done_o     (div_done)
  );

  frs_div #(.W(W)) u_div_denom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (den_q),
    .divisor_i  (a_q),
    .quot_o     (qd),
    .done_o     (div_done_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_numer_q <= '0;
      acc_denom_q <= (S - 1)'(1);
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      acc_numer_q <= acc_numer_d;
      acc_denom_q <= acc_denom_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    s1_q         <= s1_d;
    s2_q         <= s2_d;
    st_q         <= st_d;
    mc1_q        <= mc1_d;
    mc2_q        <= mc2_d;
    mlt_d_q      <= mlt_d_d;
    mlt_n_q      <= mlt_n_d;
    p1_q         <= p1_d;
    p2_q         <= p2_d;
    den_q        <= den_d;
    t_q          <= t_d;
    a_q          <= a_d;
    b_q          <= b_d;
    res_numer_q  <= res_numer_d;
    res_denom_q  <= res_denom_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign sum_numer_o = res_numer_q;
  assign sum_denom_o = res_denom_q;
  assign status_o    = res_status_q;
  assign list_done_o = res_last_q;

`ifndef NO_ASSERTIONS
  a_denom_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_denom_q != '0) else $error("running denominator is zero");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL || state_q == S_OUT))
    else $error("accepted transaction did not start");

  a_div_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done || div_done_d) |-> (state_q == S_DIV && div_done == div_done_d))
    else $error("divider finished outside the divide step");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_ZERO_DEN ||
                     status_o == ST_OVERFLOW))
    else $error("bad status code on result");
`endif

endmodule

// ===== rtl/frs_div.sv =====
module frs_div #(
  parameter int W = 96
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic [W-1:0] quot_o,
  output logic         done_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  q_q, q_d;
  logic [W:0]    r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    r_sh;
  logic [W+1:0]  r_diff;

  // One quotient bit per cycle, restoring form
  always_comb begin
    r_sh   = {r_q[W-1:0], x_q[W-1]};
    r_diff = {1'b0, r_sh} - {2'b00, divisor_i};
    x_d    = x_q;
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = dividend_i;
      r_d    = '0;
      q_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[W-2:0], 1'b0};
      if (!r_diff[W+1]) begin
        r_d = r_diff[W:0];
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = r_sh;
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    q_q <= q_d;
    r_q <= r_d;
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

// ===== tb/fraction_running_sum_tb.sv =====
module fraction_running_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frs_pkg::*;

  localparam int SW = 64;
  localparam int IW = 32;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [IW-1:0] numer;
    logic [IW-1:0] denom;
    logic          last;
  } frac_t;

  typedef struct packed {
    logic [SW-1:0] numer;
    logic [SW-2:0] denom;
    logic [1:0]    status;
    logic          done;
  } sum_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [IW-1:0] frac_numer_i;
  logic [IW-1:0] frac_denom_i;
  logic          last_of_list_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [SW-1:0] sum_numer_o;
  logic [SW-2:0] sum_denom_o;
  logic [1:0]    status_o;
  logic          list_done_o;

  frac_t pending_q[$];
  sum_t  expected_sums_q[$];
  int    mismatch_cnt;
  bit    stim_done = 1'b0;

  // Running sum held by the predictor
  logic signed [SW-1:0] pred_numer;
  logic [SW-1:0]        pred_denom;

  fraction_running_sum #(.SUM_WIDTH(SW), .IN_WIDTH(IW)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Binary gcd of two nonzero values
  function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
    int k;
    logic [127:0] t;
    k = 0;
    while (((a | b) & 1) == 0) begin
      a = a >> 1;
      b = b >> 1;
      k++;
    end
    while (a[0] == 0) a = a >> 1;
    while (b != 0) begin
      while (b[0] == 0) b = b >> 1;
      if (b < a) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    return a << k;
  endfunction

  // Add one fraction to the running sum and return the reported sum
  function automatic sum_t add_fraction(frac_t f);
    sum_t r;
    logic signed [127:0] n, d, t, den;
    logic [127:0] mag, g, qn, qd;
    logic [SW-1:0] lim;
    r.status = ST_OK;
    lim = 64'h1 << (SW - 1);
    n = $signed(f.numer);
    d = $signed(f.denom);
    if (d == 0) begin
      r.status = ST_ZERO_DEN;
    end else begin
      if (d < 0) begin
        d = -d;
        n = -n;
      end
      t = $signed(pred_numer) * d + n * $signed({64'd0, pred_denom});
      den = $signed({64'd0, pred_denom}) * d;
      if (t == 0) begin
        pred_numer = '0;
        pred_denom = 1;
      end else begin
        mag = (t < 0) ? -t : t;
        g = gcd128(mag, den);
        qn = mag / g;
        qd = den / g;
        if (qn[127:64] != 0 || qd[127:64] != 0 || qd[63:0] >= lim ||
            qn[63:0] > ((t < 0) ? lim : lim - 1)) begin
          r.status = ST_OVERFLOW;
        end else begin
          pred_numer = (t < 0) ? -qn[63:0] : qn[63:0];
          pred_denom = qd[63:0];
        end
      end
    end
    r.numer = pred_numer;
    r.denom = pred_denom[SW-2:0];
    r.done  = f.last;
    if (f.last) begin
      pred_numer = '0;
      pred_denom = 1;
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 1);
      4: return $urandom;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  task automatic push_item(logic [IW-1:0] n, logic [IW-1:0] d, logic l);
    frac_t f;
    f.numer = n;
    f.denom = d;
    f.last  = l;
    pending_q.push_back(f);
  endtask

  // Fill the stimulus queue
  initial begin
    int len;
    logic [IW-1:0] dv;
    push_item(32'd1, 32'd2, 1'b0);
    push_item(32'd1, 32'd3, 1'b0);
    push_item(-32'sd5, 32'd6, 1'b1);
    push_item(32'd7, 32'd0, 1'b0);
    push_item(32'd3, -32'sd4, 1'b0);
    push_item(32'd9, 32'd0, 1'b1);
    push_item(32'h7fff_ffff, 32'd1, 1'b0);
    push_item(32'h7fff_ffff, 32'd1, 1'b0);
    push_item(32'h8000_0000, 32'h8000_0000, 1'b1);
    push_item(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    push_item(32'd1, 32'h7fff_fffe, 1'b0);
    push_item(32'd1, 32'h7fff_fffd, 1'b0);
    push_item(32'd1, 32'h7fff_fffb, 1'b1);
    push_item(32'd0, 32'h8000_0000, 1'b0);
    push_item(32'd4, 32'd8, 1'b0);
    push_item(-32'sd1, 32'd2, 1'b1);
    push_item(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    push_item(32'h7fff_ffff, 32'h7fff_fff1, 1'b0);
    push_item(32'h7fff_ffff, 32'h7fff_ffe3, 1'b0);
    push_item(32'h7fff_ffff, 32'h7fff_ffc9, 1'b1);
    while (pending_q.size() < 1920) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        dv = rand_value();
        if ($urandom_range(0, 15) == 0) dv = '0;
        push_item(rand_value(), dv, i == len - 1);
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: present one transaction, then wait a random gap
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      frac_numer_i   <= '0;
      frac_denom_i   <= '0;
      last_of_list_i <= 1'b0;
      in_gap         <= 0;
      pred_numer     = '0;
      pred_denom     = 1;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_sums_q.push_back(add_fraction(
          {frac_numer_i, frac_denom_i, last_of_list_i}));
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending_q.size() != 0) begin
        frac_t f;
        f = pending_q.pop_front();
        in_valid_i     <= 1'b1;
        frac_numer_i   <= f.numer;
        frac_denom_i   <= f.denom;
        last_of_list_i <= f.last;
        in_gap         <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: random wait per result, one long hold early on
  int unsigned out_wait;
  int unsigned hold_cnt;
  int unsigned result_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait    <= 0;
      hold_cnt    <= 0;
      result_cnt  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        result_cnt <= result_cnt + 1;
        if (result_cnt == 30) hold_cnt <= LONG_HOLD;
        out_wait <= (result_cnt > 1000 && result_cnt < 1200) ? 0 : $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (out_wait != 0) begin
        out_wait    <= out_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sums_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %0d/%0d", sum_numer_o, sum_denom_o);
      end else begin
        sum_t e;
        e = expected_sums_q.pop_front();
        if (e.numer !== sum_numer_o || e.denom !== sum_denom_o ||
            e.status !== status_o || e.done !== list_done_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %0d/%0d st %0d done %0d, got %0d/%0d st %0d done %0d",
                     $signed(e.numer), e.denom, e.status, e.done,
                     $signed(sum_numer_o), sum_denom_o, status_o, list_done_o);
        end
      end
    end
  end

  // End of run
  initial begin
    mismatch_cnt = 0;
    wait (stim_done);
    @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_sums_q.size() != 0)
      @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_sums_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(20ns * 10000000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
